// ----- rtl/segment_intersection_classifier_core_macros.svh -----
// Assertion macros used by the top level of the segment intersection classifier RTL.
`ifndef SEGMENT_INTERSECTION_CLASSIFIER_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_CLASSIFIER_CORE_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define SIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, checked outside reset.
`define SIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sic_pkg.sv -----
// Package with widths, codes and payload types of the segment intersection classifier.
package sic_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DW = COORD_BITS + 1;   // coordinate difference
  localparam int PW = 2 * DW;           // product of two differences
  localparam int AW = PW + 1;           // difference of two products
  localparam int QW = FRAC_BITS + 1;    // ratio width
  localparam int NPROD = 12;
  localparam int NAREA = 6;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_CROSS   = 2'd1,
    KIND_TOUCH   = 2'd2,
    KIND_OVERLAP = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
  } seg_pair_t;

  typedef struct packed {
    kind_e           kind;
    logic [QW-1:0]   s_ratio;
    logic [QW-1:0]   t_ratio;
  } seg_result_t;

  // Handshake and class of one item moving between datapath cells.
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } cell_ctl_t;

endpackage

// ----- rtl/segment_intersection_classifier_core.sv -----
// Top level of the segment pair intersection classifier: front stages and divider cell row.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_stall_o | in_data_i  (seg_pair_t)
//   output  | out       | out_valid_o / out_stall_i | out_data_o (seg_result_t)
//
// One pair enters per cycle while the first stage has room. The 20 register stages
// are three for differences, products and areas, then one cell per quotient bit.
// Every stage holds its item until the next stage has room, so bubbles close up and
// input is still taken while a result waits at the output, until all 20 stages are full.
// Reset empties all stages; no item is in flight afterwards.
module segment_intersection_classifier_core import sic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  seg_pair_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output seg_result_t out_data_o
);

  `include "segment_intersection_classifier_core_macros.svh"

  cell_ctl_t     ctl  [QW+1];
  logic          rdy  [QW+1];
  logic [AW-1:0] rs   [QW+1];
  logic [AW-1:0] rt   [QW+1];
  logic [AW-1:0] m    [QW+1];
  logic [QW-1:0] qs   [QW+1];
  logic [QW-1:0] qt   [QW+1];
  logic          front_ready;

  sic_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (front_ready),
    .data_i    (in_data_i),
    .ctl_o     (ctl[0]),
    .ready_i   (rdy[0]),
    .ns_abs_o  (rs[0]),
    .nt_abs_o  (rt[0]),
    .den_abs_o (m[0])
  );

  assign qs[0] = '0;
  assign qt[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sic_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[i]),
      .ready_o (rdy[i]),
      .rs_i    (rs[i]),
      .rt_i    (rt[i]),
      .m_i     (m[i]),
      .qs_i    (qs[i]),
      .qt_i    (qt[i]),
      .ctl_o   (ctl[i+1]),
      .ready_i (rdy[i+1]),
      .rs_o    (rs[i+1]),
      .rt_o    (rt[i+1]),
      .m_o     (m[i+1]),
      .qs_o    (qs[i+1]),
      .qt_o    (qt[i+1])
    );
  end

  assign rdy[QW] = !out_stall_i;

  assign in_stall_o         = !front_ready;
  assign out_valid_o        = ctl[QW].valid;
  assign out_data_o.kind    = ctl[QW].kind;
  assign out_data_o.s_ratio = qs[QW];
  assign out_data_o.t_ratio = qt[QW];

  `SIC_ASSERT_NOW(a_no_ratio_without_hit, out_valid_o && (out_data_o.kind == KIND_NONE || out_data_o.kind == KIND_OVERLAP), out_data_o.s_ratio == '0 && out_data_o.t_ratio == '0, "ratio set for a pair without a crossing")
  `SIC_ASSERT_NOW(a_ratio_in_unit, out_valid_o && (out_data_o.kind == KIND_CROSS || out_data_o.kind == KIND_TOUCH), out_data_o.s_ratio <= (QW'(1) << FRAC_BITS) && out_data_o.t_ratio <= (QW'(1) << FRAC_BITS), "ratio above one")
  `SIC_ASSERT_NOW(a_take_when_empty, !out_valid_o, !in_stall_o, "input stalled with output empty")
  `SIC_ASSERT_NEXT(a_drain_moves, out_valid_o && !out_stall_i && !ctl[QW-1].valid, !out_valid_o, "result transfer repeated")

endmodule

// ----- rtl/sic_front.sv -----
// Difference, product and area stages followed by the classification of the pair.
module sic_front import sic_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  seg_pair_t       data_i,
  output cell_ctl_t       ctl_o,
  input  logic            ready_i,
  output logic [AW-1:0]   ns_abs_o,
  output logic [AW-1:0]   nt_abs_o,
  output logic [AW-1:0]   den_abs_o
);

  logic                 v1_q, v2_q, v3_q;
  logic                 rdy1, rdy2, rdy3;
  logic signed [DW-1:0] opa_d [NPROD];
  logic signed [DW-1:0] opb_d [NPROD];
  logic signed [DW-1:0] opa_q [NPROD];
  logic signed [DW-1:0] opb_q [NPROD];
  logic signed [PW-1:0] prod_q [NPROD];
  logic signed [AW-1:0] area_q [NAREA];
  logic [3:0]           rng_d, rng1_q, rng2_q, rng3_q;

  logic signed [DW-1:0] bax, bay, cax, cay, dax, day, dcx, dcy, acx, acy, bcx, bcy;
  logic signed [DW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = DW'(data_i.ax);
  assign ay = DW'(data_i.ay);
  assign bx = DW'(data_i.bx);
  assign by = DW'(data_i.by);
  assign cx = DW'(data_i.cx);
  assign cy = DW'(data_i.cy);
  assign dx = DW'(data_i.dx);
  assign dy = DW'(data_i.dy);

  assign bax = bx - ax;
  assign bay = by - ay;
  assign cax = cx - ax;
  assign cay = cy - ay;
  assign dax = dx - ax;
  assign day = dy - ay;
  assign dcx = dx - cx;
  assign dcy = dy - cy;
  assign acx = ax - cx;
  assign acy = ay - cy;
  assign bcx = bx - cx;
  assign bcy = by - cy;

  // Operand pairs; each area is the difference of two neighbouring products.
  always_comb begin
    opa_d[0]  = bay; opb_d[0]  = dcx;   // denominator
    opa_d[1]  = bax; opb_d[1]  = dcy;
    opa_d[2]  = bax; opb_d[2]  = cay;   // t numerator, area of a b c
    opa_d[3]  = cax; opb_d[3]  = bay;
    opa_d[4]  = dax; opb_d[4]  = cay;   // s numerator
    opa_d[5]  = cax; opb_d[5]  = day;
    opa_d[6]  = bax; opb_d[6]  = day;   // area of a b d
    opa_d[7]  = dax; opb_d[7]  = bay;
    opa_d[8]  = dcx; opb_d[8]  = acy;   // area of c d a
    opa_d[9]  = acx; opb_d[9]  = dcy;
    opa_d[10] = dcx; opb_d[10] = bcy;   // area of c d b
    opa_d[11] = bcx; opb_d[11] = dcy;
  end

  function automatic logic in_range(input logic signed [DW-1:0] px, input logic signed [DW-1:0] py,
                                    input logic signed [DW-1:0] qx, input logic signed [DW-1:0] qy,
                                    input logic signed [DW-1:0] rx, input logic signed [DW-1:0] ry);
    logic res;
    if (px != qx) begin
      res = (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
    end else begin
      res = (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
    end
    return res;
  endfunction

  assign rng_d[0] = in_range(ax, ay, bx, by, cx, cy);
  assign rng_d[1] = in_range(ax, ay, bx, by, dx, dy);
  assign rng_d[2] = in_range(cx, cy, dx, dy, ax, ay);
  assign rng_d[3] = in_range(cx, cy, dx, dy, bx, by);

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      opa_q  <= opa_d;
      opb_q  <= opb_d;
      rng1_q <= rng_d;
    end
    if (rdy2 && v1_q) begin
      for (int k = 0; k < NPROD; k++) prod_q[k] <= opa_q[k] * opb_q[k];
      rng2_q <= rng1_q;
    end
    if (rdy3 && v2_q) begin
      for (int j = 0; j < NAREA; j++) begin
        area_q[j] <= AW'(prod_q[2*j]) - AW'(prod_q[2*j+1]);
      end
      rng3_q <= rng2_q;
    end
  end

  logic signed [AW-1:0] den, nt, ns;
  logic                 c_ab, d_ab, a_cd, b_cd, outside, touch;
  kind_e                kind;

  assign den = area_q[0];
  assign nt  = area_q[1];
  assign ns  = area_q[2];

  assign c_ab = rng3_q[0];
  assign d_ab = rng3_q[1] && (area_q[3] == '0);
  assign a_cd = rng3_q[2] && (area_q[4] == '0);
  assign b_cd = rng3_q[3] && (area_q[5] == '0);

  assign outside = (ns > 0 && ns > den) || (ns < 0 && ns < den) ||
                   (nt > 0 && nt > den) || (nt < 0 && nt < den);
  assign touch   = (ns == '0) || (ns == den) || (nt == '0) || (nt == den);

  always_comb begin
    if (den == '0) begin
      if (nt == '0 && ((c_ab && d_ab) || (a_cd && b_cd) || (c_ab && b_cd) ||
                       (c_ab && a_cd) || (d_ab && b_cd) || (d_ab && a_cd))) begin
        kind = KIND_OVERLAP;
      end else begin
        kind = KIND_NONE;
      end
    end else if (outside) begin
      kind = KIND_NONE;
    end else if (touch) begin
      kind = KIND_TOUCH;
    end else begin
      kind = KIND_CROSS;
    end
  end

  // Pairs without a ratio divide zero by one so the quotients come out as zero.
  always_comb begin
    if (kind == KIND_CROSS || kind == KIND_TOUCH) begin
      ns_abs_o  = ns[AW-1]  ? AW'(-ns)  : AW'(ns);
      nt_abs_o  = nt[AW-1]  ? AW'(-nt)  : AW'(nt);
      den_abs_o = den[AW-1] ? AW'(-den) : AW'(den);
    end else begin
      ns_abs_o  = '0;
      nt_abs_o  = '0;
      den_abs_o = AW'(1);
    end
  end

  assign ctl_o.valid = v3_q;
  assign ctl_o.kind  = kind;

endmodule

// ----- rtl/sic_div_cell.sv -----
// One restoring division cell: yields one quotient bit of each ratio and passes on.
module sic_div_cell import sic_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  output logic          ready_o,
  input  logic [AW-1:0] rs_i,
  input  logic [AW-1:0] rt_i,
  input  logic [AW-1:0] m_i,
  input  logic [QW-1:0] qs_i,
  input  logic [QW-1:0] qt_i,
  output cell_ctl_t     ctl_o,
  input  logic          ready_i,
  output logic [AW-1:0] rs_o,
  output logic [AW-1:0] rt_o,
  output logic [AW-1:0] m_o,
  output logic [QW-1:0] qs_o,
  output logic [QW-1:0] qt_o
);

  logic          valid_q;
  kind_e         kind_q;
  logic [AW-1:0] rs_q, rt_q, m_q, rs_d, rt_d;
  logic [QW-1:0] qs_q, qt_q;
  logic          bs, bt;

  assign ready_o = !valid_q || ready_i;

  assign bs   = rs_i >= m_i;
  assign bt   = rt_i >= m_i;
  assign rs_d = (bs ? rs_i - m_i : rs_i) << 1;
  assign rt_d = (bt ? rt_i - m_i : rt_i) << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      kind_q <= ctl_i.kind;
      rs_q   <= rs_d;
      rt_q   <= rt_d;
      m_q    <= m_i;
      qs_q   <= {qs_i[QW-2:0], bs};
      qt_q   <= {qt_i[QW-2:0], bt};
    end
  end

  assign ctl_o.valid = valid_q;
  assign ctl_o.kind  = kind_q;
  assign rs_o = rs_q;
  assign rt_o = rt_q;
  assign m_o  = m_q;
  assign qs_o = qs_q;
  assign qt_o = qt_q;

endmodule

// ----- tb/tb_segment_intersection_classifier_core.sv -----
// Self-checking testbench for the segment pair intersection classifier core.
module tb_segment_intersection_classifier_core import sic_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 850;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  seg_pair_t   in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  seg_result_t out_data_o;

  segment_intersection_classifier_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  seg_pair_t   pending_pairs[$];
  seg_result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};
  int unsigned idle_cycles = 0;
  bit          stimulus_done = 1'b0;
  bit          hold_req = 1'b0;

  // Appends one pair to the stimulus queue.
  function automatic void queue_pair(seg_pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  // Quotient floor(|n| * 2^FRAC_BITS / |d|) by restoring division.
  function automatic logic [QW-1:0] unit_ratio(logic signed [AW-1:0] n,
                                               logic signed [AW-1:0] d);
    logic [AW+FRAC_BITS:0] rem;
    logic [AW+FRAC_BITS:0] dvs;
    logic [QW-1:0]         quo;
    rem = n < 0 ? -n : n;
    rem = rem << FRAC_BITS;
    dvs = d < 0 ? -d : d;
    quo = '0;
    for (int i = FRAC_BITS; i >= 0; i--) begin
      if (rem >= (dvs << i)) begin
        rem -= dvs << i;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Twice the signed area of triangle pqr.
  function automatic logic signed [AW-1:0] tri_area(
      logic signed [DW:0] px, logic signed [DW:0] py, logic signed [DW:0] qx,
      logic signed [DW:0] qy, logic signed [DW:0] rx, logic signed [DW:0] ry);
    logic signed [AW+1:0] p1, p2;
    p1 = (qx - px) * (ry - py);
    p2 = (rx - px) * (qy - py);
    return AW'(p1 - p2);
  endfunction

  // Point r lies on the closed segment pq.
  function automatic bit on_segment(
      logic signed [DW:0] px, logic signed [DW:0] py, logic signed [DW:0] qx,
      logic signed [DW:0] qy, logic signed [DW:0] rx, logic signed [DW:0] ry);
    if (tri_area(px, py, qx, qy, rx, ry) != 0) return 1'b0;
    if (px != qx) return (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
    return (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
  endfunction

  function automatic bit beyond_unit(logic signed [AW-1:0] n, logic signed [AW-1:0] d);
    return (n > 0 && n > d) || (n < 0 && n < d);
  endfunction

  function automatic seg_result_t classify_pair(seg_pair_t p);
    logic signed [DW:0]    ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [AW+1:0]  p1, p2;
    logic signed [AW-1:0]  den, ns, nt;
    bit                    c_ab, d_ab, a_cd, b_cd;
    seg_result_t           r;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
    r = '{kind: KIND_NONE, s_ratio: '0, t_ratio: '0};
    p1 = (ax - bx) * (dy - cy);
    p2 = (ay - by) * (dx - cx);
    den = AW'(p1 - p2);
    nt = tri_area(ax, ay, bx, by, cx, cy);
    if (den == 0) begin
      if (nt != 0) return r;
      c_ab = on_segment(ax, ay, bx, by, cx, cy);
      d_ab = on_segment(ax, ay, bx, by, dx, dy);
      a_cd = on_segment(cx, cy, dx, dy, ax, ay);
      b_cd = on_segment(cx, cy, dx, dy, bx, by);
      if ((c_ab && d_ab) || (a_cd && b_cd) || (c_ab && b_cd) ||
          (c_ab && a_cd) || (d_ab && b_cd) || (d_ab && a_cd))
        r.kind = KIND_OVERLAP;
      return r;
    end
    p1 = (dx - ax) * (cy - ay);
    p2 = (cx - ax) * (dy - ay);
    ns = AW'(p1 - p2);
    if (beyond_unit(ns, den) || beyond_unit(nt, den)) return r;
    if (ns == 0 || ns == den || nt == 0 || nt == den) r.kind = KIND_TOUCH;
    else r.kind = KIND_CROSS;
    r.s_ratio = unit_ratio(ns, den);
    r.t_ratio = unit_ratio(nt, den);
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p = '{ax: ax, ay: ay, bx: bx, by: by, cx: cx, cy: cy, dx: dx, dy: dy};
    return p;
  endfunction

  // Mostly pairs built to meet, collinear or touching, with random content.
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int        k, m;
    p = '{ax: rand_coord(), ay: rand_coord(), bx: rand_coord(), by: rand_coord(),
          cx: rand_coord(), cy: rand_coord(), dx: rand_coord(), dy: rand_coord()};
    case ($urandom_range(0, 4))
      0: begin
        // Second segment on the line of the first.
        k = $urandom_range(0, 6); m = $urandom_range(0, 6);
        p.ax = $signed($urandom_range(0, 200)) - 100;
        p.ay = $signed($urandom_range(0, 200)) - 100;
        p.bx = p.ax + 3 * ($signed($urandom_range(0, 4)) - 2);
        p.by = p.ay + 3 * ($signed($urandom_range(0, 4)) - 2);
        p.cx = p.ax + (p.bx - p.ax) * (k - 2) / 2;
        p.cy = p.ay + (p.by - p.ay) * (k - 2) / 2;
        p.dx = p.ax + (p.bx - p.ax) * (m - 2) / 2;
        p.dy = p.ay + (p.by - p.ay) * (m - 2) / 2;
      end
      1: begin
        // Endpoint shared.
        p.cx = p.bx; p.cy = p.by;
      end
      2: begin
        // Small crossing segments.
        p.ax = $signed($urandom_range(0, 20)) - 10; p.ay = $signed($urandom_range(0, 20)) - 10;
        p.bx = -p.ax; p.by = -p.ay;
        p.cx = $signed($urandom_range(0, 20)) - 10; p.cy = $signed($urandom_range(0, 20)) - 10;
        p.dx = -p.cx; p.dy = -p.cy;
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int mx, mn;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000;
    // Directed: crossing, touches, overlap, single shared point, parallel, degenerate.
    queue_pair(make_pair(0, 0, 4, 4, 0, 4, 4, 0));
    queue_pair(make_pair(0, 0, 4, 0, 4, 0, 4, 5));
    queue_pair(make_pair(0, 0, 4, 0, 2, 0, 2, 5));
    queue_pair(make_pair(0, 0, 4, 0, 2, 0, 8, 0));
    queue_pair(make_pair(0, 0, 4, 0, 4, 0, 8, 0));
    queue_pair(make_pair(0, 0, 4, 0, 5, 0, 8, 0));
    queue_pair(make_pair(0, 0, 4, 0, 0, 1, 4, 1));
    queue_pair(make_pair(0, 0, 0, 4, 0, 2, 0, 9));
    queue_pair(make_pair(0, 0, 0, 4, 0, 5, 0, 9));
    queue_pair(make_pair(1, 1, 1, 1, 1, 1, 1, 1));
    queue_pair(make_pair(1, 1, 1, 1, 0, 0, 2, 2));
    queue_pair(make_pair(1, 1, 1, 1, 5, 0, 2, 2));
    queue_pair(make_pair(0, 0, 10, 0, 20, -1, 20, 1));
    queue_pair(make_pair(0, 0, 3, 0, 1, -1, 1, 2));
    queue_pair(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
    queue_pair(make_pair(mx, mn, mn, mx, mn, mn, mx, mx));
    queue_pair(make_pair(mn, mn, mx, mn, mn, mn, mx, mn));
    queue_pair(make_pair(mn, mx, mx, mx, 0, mn, 0, mx));
    queue_pair(make_pair(mx, mx, mn, mn, -1, -1, 0, 0));
    queue_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    queue_pair(make_pair(mn, 0, mx, 1, 0, mn, 1, mx));
    for (int i = 0; i < NUM_RANDOM; i++) queue_pair(rand_pair());
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: one pair at a time with a random gap before each.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results = {expected_results, classify_pair(in_data_i)};
        pairs_sent++;
        send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0 || pending_pairs.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
          if (pending_pairs.size() == 0) stimulus_done <= 1'b1;
        end else begin
          in_data_i <= pending_pairs.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Long receiver hold-off once the run is under way, so the pipeline backs up.
  int hold_count = 0;
  always @(posedge clk_i) begin
    if (rst_ni && pairs_sent >= 200 && hold_count < HOLD_CYCLES) begin
      hold_req <= 1'b1;
      hold_count++;
    end else begin
      hold_req <= 1'b0;
    end
  end

  // Monitor: checks each transfer and draws the receiver's stall pattern.
  int stall_left = 0;
  always @(posedge clk_i) begin
    seg_result_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("Unexpected result transfer: %p", out_data_o);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          kind_count[exp_res.kind]++;
          if (out_data_o.kind !== exp_res.kind) begin
            $error("kind: expected %0d, got %0d", exp_res.kind, out_data_o.kind);
            errors++;
          end
          if (out_data_o.s_ratio !== exp_res.s_ratio) begin
            $error("s_ratio: expected %0d, got %0d", exp_res.s_ratio, out_data_o.s_ratio);
            errors++;
          end
          if (out_data_o.t_ratio !== exp_res.t_ratio) begin
            $error("t_ratio: expected %0d, got %0d", exp_res.t_ratio, out_data_o.t_ratio);
            errors++;
          end
        end
        stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      end
      if (stall_left > 0) stall_left--;
      out_stall_i <= hold_req || stall_left > 0;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && rst_ni);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (FRAC_BITS + 30) @(posedge clk_i);
    $display("Sent %0d pairs, checked %0d results", pairs_sent, results_seen);
    $display("Kinds seen: none %0d, cross %0d, touch %0d, overlap %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sic_pkg.sv
rtl/sic_front.sv
rtl/sic_div_cell.sv
rtl/segment_intersection_classifier_core.sv
tb/tb_segment_intersection_classifier_core.sv
